// ===== src/bse_pkg.sv =====
// Shared types and constants for the bubble sort engine.
// No dependencies; used by the controller, datapath and top level.
package bse_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VALUE_W   = 32;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CNT_W-1:0]          count_t;

	// write-data source for the element store
	typedef enum logic [1:0] {
		WR_INPUT,
		WR_MIN,
		WR_CARRY
	} wr_sel_t;

	// controller -> datapath commands
	typedef struct packed {
		logic    wr_en;
		wr_sel_t wr_sel;
		addr_t   wr_addr;
		logic    rd_en;
		addr_t   rd_addr;
		logic    carry_load;
		logic    step;
		logic    out_load;
		logic    out_last;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic swapped;
	} status_t;

endpackage

// ===== src/bubble_sort_engine_core.sv =====
// Bubble sort engine top level. Loads: one input transfer per cycle while the
// engine is loading (in_ready is low during sort and read-out). Sort: at most n - 1
// passes, ending after the first pass without a swap. Read-out: each value is read
// from the store, loaded into the output register and held until taken.
// Reset (arst_n, async) empties the list; store contents stay undefined.
module bubble_sort_engine_core import bse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  value_t value_in,
	input  logic   last_in,
	output logic   out_valid,
	input  logic   out_ready,
	output value_t sorted_value,
	output logic   last_out
);

	cmd_t    cmd;
	status_t status;

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bse_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value_in     (value_in),
		.status       (status),
		.sorted_value (sorted_value),
		.last_out     (last_out)
	);

endmodule

// ===== src/bse_datapath.sv =====
// Datapath: element store, carry register, compare/swap and output register.
// Depends on bse_pkg; driven by bse_ctrl commands.
module bse_datapath import bse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  value_t  value_in,
	output status_t status,
	output value_t  sorted_value,
	output logic    last_out
);

	value_t  mem_q [MAX_ITEMS];
	value_t  rdata_q;
	value_t  carry_q;
	value_t  out_value_q;
	logic    out_last_q;
	logic    swap_q;
	logic    gt;
	value_t  wr_data;

	// the larger element rides along in carry; the smaller one is written behind
	assign gt = carry_q > rdata_q;

	always_comb begin
		case (cmd.wr_sel)
			WR_INPUT: wr_data = value_in;
			WR_MIN:   wr_data = gt ? rdata_q : carry_q;
			WR_CARRY: wr_data = carry_q;
			default:  wr_data = value_in;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[cmd.rd_addr];
		end
		if (cmd.carry_load) begin
			carry_q <= rdata_q;
		end else if (cmd.step && !gt) begin
			carry_q <= rdata_q;
		end
		if (cmd.out_load) begin
			out_value_q <= rdata_q;
			out_last_q  <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cmd.carry_load) begin
			swap_q <= 1'b0;
		end else if (cmd.step && gt) begin
			swap_q <= 1'b1;
		end
	end

	assign status.swapped = swap_q;
	assign sorted_value   = out_value_q;
	assign last_out       = out_last_q;

endmodule

// ===== src/bse_ctrl.sv =====
// Controller: load, bubble passes with early exit, and ordered read-out.
// Depends on bse_pkg; commands bse_datapath.
module bse_ctrl import bse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    last_in,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_PASS_START,
		S_PASS_FIRST,
		S_PASS_RUN,
		S_PASS_END,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t state_q;
	count_t count_q;
	count_t len_q;
	count_t k_q;
	count_t idx_q;

	logic   in_xfer;
	logic   out_xfer;
	logic   room;
	count_t count_next;
	count_t k_prev;
	count_t k_next;
	count_t len_prev;

	assign in_ready   = (state_q == S_LOAD);
	assign out_valid  = (state_q == S_EMIT_WAIT);
	assign in_xfer    = in_valid && in_ready;
	assign out_xfer   = out_valid && out_ready;
	assign room       = (count_q < CNT_W'(MAX_ITEMS));
	assign count_next = room ? count_q + CNT_W'(1) : count_q;
	assign k_prev     = k_q - CNT_W'(1);
	assign k_next     = k_q + CNT_W'(1);
	assign len_prev   = len_q - CNT_W'(1);

	always_comb begin
		cmd            = '0;
		cmd.wr_sel     = WR_INPUT;
		cmd.out_last   = (idx_q + CNT_W'(1) == count_q);
		case (state_q)
			S_LOAD: begin
				cmd.wr_en   = in_xfer && room;
				cmd.wr_addr = count_q[ADDR_W-1:0];
			end
			S_PASS_START: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = '0;
			end
			S_PASS_FIRST: begin
				cmd.carry_load = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_addr    = k_q[ADDR_W-1:0];
			end
			S_PASS_RUN: begin
				cmd.step    = 1'b1;
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_MIN;
				cmd.wr_addr = k_prev[ADDR_W-1:0];
				cmd.rd_en   = (k_next < len_q);
				cmd.rd_addr = k_next[ADDR_W-1:0];
			end
			S_PASS_END: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_CARRY;
				cmd.wr_addr = len_prev[ADDR_W-1:0];
			end
			S_EMIT_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = idx_q[ADDR_W-1:0];
			end
			S_EMIT_LD: begin
				cmd.out_load = 1'b1;
			end
			S_EMIT_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			len_q   <= '0;
			k_q     <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						count_q <= count_next;
						if (last_in) begin
							len_q <= count_next;
							idx_q <= '0;
							state_q <= (count_next < CNT_W'(2)) ? S_EMIT_RD : S_PASS_START;
						end
					end
				end
				S_PASS_START: begin
					k_q     <= CNT_W'(1);
					state_q <= S_PASS_FIRST;
				end
				S_PASS_FIRST: begin
					state_q <= S_PASS_RUN;
				end
				S_PASS_RUN: begin
					if (k_next < len_q) begin
						k_q <= k_next;
					end else begin
						state_q <= S_PASS_END;
					end
				end
				S_PASS_END: begin
					// stop after a pass with no swap, or when one element remains
					if (status.swapped && len_q > CNT_W'(2)) begin
						len_q   <= len_prev;
						state_q <= S_PASS_START;
					end else begin
						idx_q   <= '0;
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_xfer) begin
						if (idx_q + CNT_W'(1) == count_q) begin
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== tb/bubble_sort_engine_core_tb.sv =====
// Testbench for bubble_sort_engine_core: sends lists of signed values, predicts the sorted
// output per list, and checks every output transfer in order under random idling.
// Depends on bse_pkg (value_t, MAX_ITEMS) and the bubble_sort_engine_core RTL.
`timescale 1ns / 1ps

module bubble_sort_engine_core_tb;
	import bse_pkg::*;

	localparam int HOLD_CYCLES = 400;

	typedef struct {
		value_t value;
		logic   last;
	} sorted_result_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	value_t value_in;
	logic   last_in;
	logic   out_valid;
	logic   out_ready;
	value_t sorted_value;
	logic   last_out;

	// predictor state: elements of the list being loaded
	value_t list_store [MAX_ITEMS];
	int     list_len;
	sorted_result_t pending_sorted [$];

	int src_idle_pct;
	int snk_idle_pct;
	logic hold_start;
	int hold_left;

	int items_sent;
	int lists_sent;
	int values_checked;
	int mismatches;

	bubble_sort_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value_in     (value_in),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.last_out     (last_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bubble sort with early exit, then queue the whole list in ascending order
	function automatic void sort_and_queue_list();
		int n;
		value_t t;
		bit swapped;
		sorted_result_t r;
		n = list_len;
		for (int pass = 0; pass + 1 < n; pass++) begin
			swapped = 1'b0;
			for (int k = 0; k + 1 < n - pass; k++) begin
				if (list_store[k] > list_store[k+1]) begin
					t = list_store[k];
					list_store[k] = list_store[k+1];
					list_store[k+1] = t;
					swapped = 1'b1;
				end
			end
			if (!swapped)
				break;
		end
		for (int k = 0; k < n; k++) begin
			r.value = list_store[k];
			r.last  = (k == n - 1);
			pending_sorted.push_back(r);
		end
		list_len = 0;
	endfunction

	function automatic void accept_element(input value_t v, input logic l);
		// a full store drops the element, but its last flag still closes the list
		if (list_len < MAX_ITEMS) begin
			list_store[list_len] = v;
			list_len++;
		end
		if (l) begin
			lists_sent++;
			sort_and_queue_list();
		end
	endfunction

	task automatic send_element(input value_t v, input logic l);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= v;
		last_in  <= l;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		accept_element(v, l);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sorted.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
	endtask

	function automatic value_t pick_element(input int flavor);
		case (flavor)
			2: return value_t'(int'($urandom_range(0, 6)) - 3);
			3: begin
				case ($urandom_range(0, 5))
					0: return value_t'(32'h8000_0000);
					1: return value_t'(32'h8000_0001);
					2: return value_t'(32'h7FFF_FFFF);
					3: return value_t'(32'h7FFF_FFFE);
					4: return value_t'(0);
					default: return value_t'(-1);
				endcase
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	// signed ordering at both ends of the range
	task automatic test_signed_extremes();
		send_element(value_t'(32'h7FFF_FFFF), 1'b0);
		send_element(value_t'(32'h8000_0000), 1'b0);
		send_element(value_t'(0), 1'b0);
		send_element(value_t'(-1), 1'b0);
		send_element(value_t'(1), 1'b0);
		send_element(value_t'(32'h8000_0001), 1'b0);
		send_element(value_t'(32'h7FFF_FFFE), 1'b1);
	endtask

	task automatic test_single_element();
		send_element(value_t'(-5), 1'b1);
	endtask

	// descending list past capacity: worst-case sort, extra elements dropped,
	// and the dropped final element still ends the list
	task automatic test_store_full();
		for (int i = 0; i < MAX_ITEMS + 2; i++)
			send_element(value_t'(1000 - 150 * i), i == MAX_ITEMS + 1);
	endtask

	task automatic run_random_lists(input int budget);
		int len;
		int flavor;
		int start;
		value_t base;
		start = items_sent;
		while (items_sent - start < budget) begin
			flavor = $urandom_range(0, 4);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4)
			                                   : $urandom_range(1, MAX_ITEMS);
			base = value_t'($urandom);
			for (int k = 0; k < len; k++) begin
				if (flavor == 4)
					send_element(base + value_t'(k), k == len - 1);  // already sorted
				else
					send_element(pick_element(flavor), k == len - 1);
			end
		end
	endtask

	// receiver stops for a long stretch while two full lists are offered
	task automatic test_output_backpressure();
		in_valid   <= 1'b0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int l = 0; l < 2; l++)
			for (int k = 0; k < MAX_ITEMS; k++)
				send_element(value_t'($urandom), k == MAX_ITEMS - 1);
	endtask

	always @(posedge clk) begin
		sorted_result_t want;
		if (out_valid && out_ready) begin
			values_checked++;
			if (pending_sorted.size() == 0) begin
				$error("unexpected output transfer: sorted_value %0d last_out %0b",
				       sorted_value, last_out);
				mismatches++;
			end else begin
				want = pending_sorted.pop_front();
				if (sorted_value !== want.value) begin
					$error("sorted_value: expected %0d, got %0d", want.value, sorted_value);
					mismatches++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %0b, got %0b", want.last, last_out);
					mismatches++;
				end
			end
		end
		if (hold_start)
			hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("bubble_sort_engine_core: mismatch");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		value_in   = '0;
		last_in    = 1'b0;
		out_ready  = 1'b0;
		hold_start = 1'b0;
		hold_left  = 0;
		list_len   = 0;
		items_sent = 0;
		lists_sent = 0;
		values_checked = 0;
		mismatches = 0;
		set_idling(11, 83);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_signed_extremes();
		test_single_element();
		test_store_full();
		run_random_lists(80);
		test_output_backpressure();
		wait_drained();

		set_idling(83, 11);
		run_random_lists(100);
		wait_drained();

		set_idling(0, 0);
		run_random_lists(90);
		wait_drained();
		repeat (200) @(posedge clk);

		$display("Sent %0d elements in %0d lists, including overflow and long output stalls;",
		         items_sent, lists_sent);
		$display("checked %0d sorted values against the predicted ascending order.",
		         values_checked);
		if (mismatches == 0 && pending_sorted.size() == 0)
			$display("bubble_sort_engine_core: match");
		else
			$display("bubble_sort_engine_core: mismatch");
		$finish;
	end

endmodule
